// File: src/spotrad_pkg.sv
// Shared types and constants for the spot light radiance pipeline.
// No dependencies; every other file imports this package.
package spotrad_pkg;

  localparam int CHANNELS    = 3;
  localparam int CFG_W       = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int SQRT_STAGES = 32;
  localparam int DIR_BITS    = 15;
  localparam int T_BITS      = 31;
  localparam int RAD_BITS    = 32;

  localparam logic [15:0] ONE_Q14 = 16'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIGHT_POS_X       = 3'd0,
    CFG_LIGHT_POS_Y       = 3'd1,
    CFG_LIGHT_POS_Z       = 3'd2,
    CFG_SPOT_AXIS         = 3'd3,
    CFG_COS_TOTAL_WIDTH   = 3'd4,
    CFG_COS_FALLOFF_START = 3'd5,
    CFG_INTENSITY         = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] light_pos_x;
    logic [31:0] light_pos_y;
    logic [31:0] light_pos_z;
    logic [47:0] spot_axis;
    logic [15:0] cos_total_width;
    logic [15:0] cos_falloff_start;
    logic [47:0] intensity;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [31:0]        radiance_r;
    logic [31:0]        radiance_g;
    logic [31:0]        radiance_b;
    logic               coincident;
  } result_t;

  // sideband after the geometry front end
  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][31:0] n;
    logic             coin;
    logic             dbig;
    logic [63:0]      dlo;
  } geo_side_t;

  // sideband once the direction is known
  typedef struct packed {
    logic [2:0][15:0] dir;
    logic             coin;
    logic             dbig;
    logic [63:0]      dlo;
  } dir_side_t;

endpackage

// File: src/spotrad_geom.sv
// Geometry front end: offset from the light, squared distance, scaled magnitudes.
// Four register stages. Depends on spotrad_pkg.
module spotrad_geom import spotrad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  point_t      point_i,
  input  cfg_t        cfg_i,
  output logic        valid_o,
  output logic [63:0] d2_o,
  output geo_side_t   side_o
);

  logic [31:0] p [3];
  logic [31:0] lp [3];

  assign p[0]  = point_i.point_x;
  assign p[1]  = point_i.point_y;
  assign p[2]  = point_i.point_z;
  assign lp[0] = cfg_i.light_pos_x;
  assign lp[1] = cfg_i.light_pos_y;
  assign lp[2] = cfg_i.light_pos_z;

  logic [3:0] v_q;

  // stage 1: offset
  logic [33:0] d_d [3];
  logic [33:0] d_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_d[i] = {{2{p[i][31]}}, p[i]} - {{2{lp[i][31]}}, lp[i]};
    end
  end

  // stage 2: magnitude and power-of-two scaling
  logic [32:0] m_d [3];
  logic [32:0] m_q [3];
  logic [31:0] n_d [3];
  logic [31:0] n_q2 [3];
  logic [2:0]  neg_d, neg_q2;

  always_comb begin
    logic [33:0] a;
    logic [32:0] mx;
    logic [4:0]  sh;
    mx = '0;
    sh = '0;
    for (int i = 0; i < 3; i++) begin
      a        = d_q[i][33] ? 34'(-d_q[i]) : d_q[i];
      m_d[i]   = a[32:0];
      neg_d[i] = d_q[i][33];
      if (m_d[i] > mx) mx = m_d[i];
    end
    for (int b = 0; b < 31; b++) begin
      if (mx[b]) sh = 5'(30 - b);
    end
    for (int i = 0; i < 3; i++) begin
      n_d[i] = (mx[32] | mx[31]) ? m_d[i][32:1] : (m_d[i][31:0] << sh);
    end
  end

  // stage 3: squares
  logic [64:0] sq_d [3];
  logic [64:0] sq_q [3];
  logic [63:0] nn_d [3];
  logic [63:0] nn_q [3];
  logic [31:0] n_q3 [3];
  logic [2:0]  neg_q3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = 65'(m_q[i]) * 65'(m_q[i]);
      nn_d[i] = 64'(n_q2[i]) * 64'(n_q2[i]);
    end
  end

  // stage 4: sums
  logic [65:0] dsum;
  logic [63:0] d2_d;
  geo_side_t   side_d;

  always_comb begin
    dsum = 66'(sq_q[0]) + 66'(sq_q[1]) + 66'(sq_q[2]);
    d2_d = nn_q[0] + nn_q[1] + nn_q[2];
    side_d.neg  = neg_q3;
    side_d.coin = (dsum == '0);
    side_d.dbig = |dsum[65:64];
    side_d.dlo  = dsum[63:0];
    for (int i = 0; i < 3; i++) begin
      side_d.n[i] = n_q3[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q    <= d_d;
      m_q    <= m_d;
      n_q2   <= n_d;
      neg_q2 <= neg_d;
      sq_q   <= sq_d;
      nn_q   <= nn_d;
      n_q3   <= n_q2;
      neg_q3 <= neg_q2;
      d2_o   <= d2_d;
      side_o <= side_d;
    end
  end

  assign valid_o = v_q[3];

endmodule

// File: src/spotrad_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Depends on spotrad_pkg.
module spotrad_sqrt import spotrad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] x_i,
  input  geo_side_t   side_i,
  output logic        valid_o,
  output logic [31:0] root_o,
  output geo_side_t   side_o
);

  logic [63:0] x_q    [SQRT_STAGES];
  logic [31:0] r_q    [SQRT_STAGES];
  logic [33:0] rem_q  [SQRT_STAGES];
  geo_side_t   side_q [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] v_q;

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    localparam int K = SQRT_STAGES - 1 - s;
    logic [63:0] x_p;
    logic [31:0] r_p, r_d;
    logic [33:0] rem_p, rem_d;
    geo_side_t   side_p;
    logic        v_p;

    if (s == 0) begin : g_first
      assign x_p    = x_i;
      assign r_p    = '0;
      assign rem_p  = '0;
      assign side_p = side_i;
      assign v_p    = valid_i;
    end else begin : g_next
      assign x_p    = x_q[s-1];
      assign r_p    = r_q[s-1];
      assign rem_p  = rem_q[s-1];
      assign side_p = side_q[s-1];
      assign v_p    = v_q[s-1];
    end

    always_comb begin
      logic [35:0] acc, trial;
      acc   = {rem_p, x_p[2*K+1 -: 2]};
      trial = {2'b00, r_p, 2'b01};
      if (acc >= trial) begin
        rem_d = 34'(acc - trial);
        r_d   = {r_p[30:0], 1'b1};
      end else begin
        rem_d = acc[33:0];
        r_d   = {r_p[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s]    <= x_p;
        r_q[s]    <= r_d;
        rem_q[s]  <= rem_d;
        side_q[s] <= side_p;
      end
    end
  end

  assign valid_o = v_q[SQRT_STAGES-1];
  assign root_o  = r_q[SQRT_STAGES-1];
  assign side_o  = side_q[SQRT_STAGES-1];

endmodule

// File: src/spotrad_dirdiv.sv
// Direction normalization: rounded n * 2^14 / len per axis, one quotient bit per stage.
// Depends on spotrad_pkg.
module spotrad_dirdiv import spotrad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [31:0] len_i,
  input  geo_side_t   side_i,
  output logic        valid_o,
  output dir_side_t   side_o
);

  typedef struct packed {
    logic [2:0]  neg;
    logic        coin;
    logic        dbig;
    logic [63:0] dlo;
  } dq_side_t;

  // prep stage: rounded numerator
  logic [31:0] pr_rem_d [3];
  logic [31:0] pr_rem_q [3];
  logic [14:0] pr_low_d [3];
  logic [14:0] pr_low_q [3];
  logic [31:0] pr_len_q;
  dq_side_t    pr_side_d, pr_side_q;
  logic        pr_v_q;

  always_comb begin
    logic [45:0] num;
    for (int i = 0; i < 3; i++) begin
      num         = {side_i.n[i], 14'b0} + 46'(len_i >> 1);
      pr_rem_d[i] = 32'(num[45:15]);
      pr_low_d[i] = num[14:0];
    end
    pr_side_d.neg  = side_i.neg;
    pr_side_d.coin = side_i.coin;
    pr_side_d.dbig = side_i.dbig;
    pr_side_d.dlo  = side_i.dlo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_v_q <= 1'b0;
    end else if (en_i) begin
      pr_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_rem_q  <= pr_rem_d;
      pr_low_q  <= pr_low_d;
      pr_len_q  <= len_i;
      pr_side_q <= pr_side_d;
    end
  end

  // restoring division
  logic [31:0] rem_q  [DIR_BITS][3];
  logic [14:0] low_q  [DIR_BITS][3];
  logic [14:0] qt_q   [DIR_BITS][3];
  logic [31:0] len_q  [DIR_BITS];
  dq_side_t    side_q [DIR_BITS];
  logic [DIR_BITS-1:0] v_q;

  for (genvar s = 0; s < DIR_BITS; s++) begin : g_stage
    localparam int K = DIR_BITS - 1 - s;
    logic [31:0] rem_p [3];
    logic [31:0] rem_d [3];
    logic [14:0] low_p [3];
    logic [14:0] qt_p  [3];
    logic [14:0] qt_d  [3];
    logic [31:0] len_p;
    dq_side_t    side_p;
    logic        v_p;

    if (s == 0) begin : g_first
      assign rem_p  = pr_rem_q;
      assign low_p  = pr_low_q;
      assign qt_p   = '{default: '0};
      assign len_p  = pr_len_q;
      assign side_p = pr_side_q;
      assign v_p    = pr_v_q;
    end else begin : g_next
      assign rem_p  = rem_q[s-1];
      assign low_p  = low_q[s-1];
      assign qt_p   = qt_q[s-1];
      assign len_p  = len_q[s-1];
      assign side_p = side_q[s-1];
      assign v_p    = v_q[s-1];
    end

    always_comb begin
      logic [32:0] acc;
      for (int i = 0; i < 3; i++) begin
        acc = {rem_p[i], low_p[i][K]};
        if (acc >= {1'b0, len_p}) begin
          rem_d[i] = 32'(acc - {1'b0, len_p});
          qt_d[i]  = {qt_p[i][13:0], 1'b1};
        end else begin
          rem_d[i] = acc[31:0];
          qt_d[i]  = {qt_p[i][13:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        low_q[s]  <= low_p;
        qt_q[s]   <= qt_d;
        len_q[s]  <= len_p;
        side_q[s] <= side_p;
      end
    end
  end

  // sign and clamp
  dir_side_t out_d;
  logic      out_v_q;

  always_comb begin
    logic [14:0] qc;
    for (int i = 0; i < 3; i++) begin
      qc = (qt_q[DIR_BITS-1][i] > ONE_Q14[14:0]) ? ONE_Q14[14:0] : qt_q[DIR_BITS-1][i];
      out_d.dir[i] = side_q[DIR_BITS-1].neg[i] ? 16'(-{1'b0, qc}) : {1'b0, qc};
    end
    out_d.coin = side_q[DIR_BITS-1].coin;
    out_d.dbig = side_q[DIR_BITS-1].dbig;
    out_d.dlo  = side_q[DIR_BITS-1].dlo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= v_q[DIR_BITS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= out_d;
    end
  end

  assign valid_o = out_v_q;

endmodule

// File: src/spotrad_falloff.sv
// Cone falloff: cosine against the spot axis, ramp fraction, fourth power in Q1.14.
// Depends on spotrad_pkg.
module spotrad_falloff import spotrad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  dir_side_t   side_i,
  input  cfg_t        cfg_i,
  output logic        valid_o,
  output logic [14:0] f_o,
  output dir_side_t   side_o
);

  typedef enum logic [1:0] {
    FC_ZERO = 2'd0,
    FC_ONE  = 2'd1,
    FC_RAMP = 2'd2
  } fall_cls_e;

  typedef struct packed {
    fall_cls_e   cls;
    logic [30:0] num;
    dir_side_t   ds;
  } tl_side_t;

  // stage 1: products with the axis
  logic signed [15:0] dir_s [3];
  logic signed [15:0] ax_s  [3];
  logic signed [31:0] pr_d  [3];
  logic signed [31:0] pr_q  [3];
  dir_side_t          s1_side_q;
  logic               s1_v_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_s[i] = side_i.dir[i];
      ax_s[i]  = cfg_i.spot_axis[16*i +: 16];
      pr_d[i]  = 32'(dir_s[i]) * 32'(ax_s[i]);
    end
  end

  // stage 2: cosine and classification
  logic signed [33:0] c28, lo, hi;
  tl_side_t           s2_side_d, s2_side_q;
  logic               s2_v_q;

  always_comb begin
    c28 = 34'(pr_q[0]) + 34'(pr_q[1]) + 34'(pr_q[2]);
    lo  = {{4{cfg_i.cos_total_width[15]}}, cfg_i.cos_total_width, 14'b0};
    hi  = {{4{cfg_i.cos_falloff_start[15]}}, cfg_i.cos_falloff_start, 14'b0};
    priority if (c28 < lo) begin
      s2_side_d.cls = FC_ZERO;
    end else if (c28 > hi || hi == lo) begin
      s2_side_d.cls = FC_ONE;
    end else begin
      s2_side_d.cls = FC_RAMP;
    end
    s2_side_d.num = 31'(c28 - lo);
    s2_side_d.ds  = s1_side_q;
  end

  // ramp width in Q1.14 units; positive whenever the ramp applies
  logic [16:0] dd_full;
  logic [15:0] dd;

  assign dd_full = {cfg_i.cos_falloff_start[15], cfg_i.cos_falloff_start}
                 - {cfg_i.cos_total_width[15], cfg_i.cos_total_width};
  assign dd      = dd_full[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q      <= pr_d;
      s1_side_q <= side_i;
      s2_side_q <= s2_side_d;
    end
  end

  // t = floor(num * 2^16 / dd), one bit per stage
  logic [15:0] rem_q  [T_BITS];
  logic [30:0] t_q    [T_BITS];
  tl_side_t    side_q [T_BITS];
  logic [T_BITS-1:0] v_q;

  for (genvar s = 0; s < T_BITS; s++) begin : g_stage
    localparam int K = T_BITS - 1 - s;
    logic [15:0] rem_p, rem_d;
    logic [30:0] t_p, t_d;
    tl_side_t    side_p;
    logic        v_p;
    logic [46:0] nfull;

    if (s == 0) begin : g_first
      assign rem_p  = s2_side_q.num[30:15];
      assign t_p    = '0;
      assign side_p = s2_side_q;
      assign v_p    = s2_v_q;
    end else begin : g_next
      assign rem_p  = rem_q[s-1];
      assign t_p    = t_q[s-1];
      assign side_p = side_q[s-1];
      assign v_p    = v_q[s-1];
    end

    assign nfull = {side_p.num, 16'b0};

    always_comb begin
      logic [16:0] acc;
      acc = {rem_p, nfull[K]};
      if (acc >= {1'b0, dd}) begin
        rem_d = 16'(acc - {1'b0, dd});
        t_d   = {t_p[29:0], 1'b1};
      end else begin
        rem_d = acc[15:0];
        t_d   = {t_p[29:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        t_q[s]    <= t_d;
        side_q[s] <= side_p;
      end
    end
  end

  // t^2, t^4 rounded in Q0.30, then rounded to Q1.14
  logic [61:0] sq2, sq4;
  logic [30:0] t2_d, t2_q, t4_d, t4_q;
  tl_side_t    p1_side_q, p2_side_q;
  logic        p1_v_q, p2_v_q, p3_v_q;
  logic [30:0] fr;
  logic [14:0] f_d;

  always_comb begin
    sq2  = 62'(t_q[T_BITS-1]) * 62'(t_q[T_BITS-1]);
    t2_d = 31'((sq2 + (62'd1 << 29)) >> 30);
    sq4  = 62'(t2_q) * 62'(t2_q);
    t4_d = 31'((sq4 + (62'd1 << 29)) >> 30);
    fr   = t4_q + (31'd1 << 15);
    unique case (p2_side_q.cls)
      FC_ZERO: f_d = '0;
      FC_ONE:  f_d = ONE_Q14[14:0];
      FC_RAMP: f_d = fr[30:16];
      default: f_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
    end else if (en_i) begin
      p1_v_q <= v_q[T_BITS-1];
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2_q      <= t2_d;
      p1_side_q <= side_q[T_BITS-1];
      t4_q      <= t4_d;
      p2_side_q <= p1_side_q;
      f_o       <= f_d;
      side_o    <= p2_side_q.ds;
    end
  end

  assign valid_o = p3_v_q;

endmodule

// File: src/spotrad_radiance.sv
// Radiance: intensity times falloff over squared distance, saturating, plus output register.
// Depends on spotrad_pkg.
module spotrad_radiance import spotrad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [14:0] f_i,
  input  dir_side_t   side_i,
  input  cfg_t        cfg_i,
  output logic        valid_o,
  output result_t     res_o
);

  typedef struct packed {
    logic [2:0][15:0] dir;
    logic             coin;
    logic             zero;
    logic [2:0]       sat;
    logic [63:0]      dlo;
  } rd_side_t;

  // stage 0: channel times falloff
  logic [30:0] prod_d [3];
  logic [30:0] prod_q [3];
  dir_side_t   s0_side_q;
  logic        s0_v_q;

  always_comb begin
    logic [15:0] chan;
    for (int i = 0; i < 3; i++) begin
      chan      = (i < CHANNELS) ? cfg_i.intensity[16*i +: 16] : 16'd0;
      prod_d[i] = 31'(chan) * 31'(f_i);
    end
  end

  // stage 1: saturation check and initial remainder
  logic [63:0] r1_rem_d [3];
  logic [63:0] r1_rem_q [3];
  logic [30:0] r1_prod_q [3];
  rd_side_t    r1_side_d, r1_side_q;
  logic        r1_v_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r1_rem_d[i]      = 64'(prod_q[i][30:6]);
      r1_side_d.sat[i] = (r1_rem_d[i] >= s0_side_q.dlo);
    end
    r1_side_d.dir  = s0_side_q.dir;
    r1_side_d.coin = s0_side_q.coin;
    r1_side_d.zero = s0_side_q.coin | s0_side_q.dbig;
    r1_side_d.dlo  = s0_side_q.dlo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      r1_v_q <= 1'b0;
    end else if (en_i) begin
      s0_v_q <= valid_i;
      r1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= prod_d;
      s0_side_q <= side_i;
      r1_rem_q  <= r1_rem_d;
      r1_prod_q <= prod_q;
      r1_side_q <= r1_side_d;
    end
  end

  // quotient bits of prod * 2^26 / D
  logic [63:0] rem_q  [RAD_BITS][3];
  logic [30:0] prd_q  [RAD_BITS][3];
  logic [31:0] qt_q   [RAD_BITS][3];
  rd_side_t    side_q [RAD_BITS];
  logic [RAD_BITS-1:0] v_q;

  for (genvar s = 0; s < RAD_BITS; s++) begin : g_stage
    localparam int K = RAD_BITS - 1 - s;
    logic [63:0] rem_p [3];
    logic [63:0] rem_d [3];
    logic [30:0] prd_p [3];
    logic [31:0] qt_p  [3];
    logic [31:0] qt_d  [3];
    rd_side_t    side_p;
    logic        v_p;

    if (s == 0) begin : g_first
      assign rem_p  = r1_rem_q;
      assign prd_p  = r1_prod_q;
      assign qt_p   = '{default: '0};
      assign side_p = r1_side_q;
      assign v_p    = r1_v_q;
    end else begin : g_next
      assign rem_p  = rem_q[s-1];
      assign prd_p  = prd_q[s-1];
      assign qt_p   = qt_q[s-1];
      assign side_p = side_q[s-1];
      assign v_p    = v_q[s-1];
    end

    always_comb begin
      logic [64:0] acc;
      logic [56:0] nfull;
      for (int i = 0; i < 3; i++) begin
        nfull = {prd_p[i], 26'b0};
        acc   = {rem_p[i], nfull[K]};
        if (acc >= {1'b0, side_p.dlo}) begin
          rem_d[i] = 64'(acc - {1'b0, side_p.dlo});
          qt_d[i]  = {qt_p[i][30:0], 1'b1};
        end else begin
          rem_d[i] = acc[63:0];
          qt_d[i]  = {qt_p[i][30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        prd_q[s]  <= prd_p;
        qt_q[s]   <= qt_d;
        side_q[s] <= side_p;
      end
    end
  end

  // output register
  rd_side_t    fin;
  logic [31:0] rad [3];
  result_t     res_d;
  logic        out_v_q;

  always_comb begin
    fin = side_q[RAD_BITS-1];
    for (int i = 0; i < 3; i++) begin
      priority if (fin.zero) begin
        rad[i] = '0;
      end else if (fin.sat[i]) begin
        rad[i] = '1;
      end else begin
        rad[i] = qt_q[RAD_BITS-1][i];
      end
    end
    res_d.dir_x      = fin.coin ? 16'sd0 : fin.dir[0];
    res_d.dir_y      = fin.coin ? 16'sd0 : fin.dir[1];
    res_d.dir_z      = fin.coin ? 16'sd0 : fin.dir[2];
    res_d.radiance_r = rad[0];
    res_d.radiance_g = rad[1];
    res_d.radiance_b = rad[2];
    res_d.coincident = fin.coin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= v_q[RAD_BITS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
    end
  end

  assign valid_o = out_v_q;

endmodule

// File: src/spot_light_sample_radiance_core.sv
// Spot light radiance toward a stream of surface points; one point per clock while no
// result is stalled at the output. The pipeline is built from the bit-per-stage units:
// a 32-stage square root, a 15-stage direction divider, a 31-stage ramp divider and a
// 32-stage distance divider, plus 14 setup stages.
// A stalled result holds the whole pipeline, so input is stalled in that cycle.
// Configuration must be written only while the pipeline is empty.
// Top level; depends on spotrad_pkg and the spotrad_* stage modules.
module spot_light_sample_radiance_core import spotrad_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  point_t               in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output result_t              out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{light_pos_x: '0, light_pos_y: '0, light_pos_z: '0, spot_axis: '0,
                 cos_total_width: '0, cos_falloff_start: ONE_Q14, intensity: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LIGHT_POS_X:       cfg_q.light_pos_x       <= cfg_data_i[31:0];
        CFG_LIGHT_POS_Y:       cfg_q.light_pos_y       <= cfg_data_i[31:0];
        CFG_LIGHT_POS_Z:       cfg_q.light_pos_z       <= cfg_data_i[31:0];
        CFG_SPOT_AXIS:         cfg_q.spot_axis         <= cfg_data_i;
        CFG_COS_TOTAL_WIDTH:   cfg_q.cos_total_width   <= cfg_data_i[15:0];
        CFG_COS_FALLOFF_START: cfg_q.cos_falloff_start <= cfg_data_i[15:0];
        CFG_INTENSITY:         cfg_q.intensity         <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // whole pipeline advances unless a result is held at the output
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic        geo_v, sq_v, dd_v, fo_v;
  logic [63:0] d2;
  logic [31:0] len;
  geo_side_t   geo_side, sq_side;
  dir_side_t   dd_side, fo_side;
  logic [14:0] f;

  spotrad_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .point_i (in_data_i),
    .cfg_i   (cfg_q),
    .valid_o (geo_v),
    .d2_o    (d2),
    .side_o  (geo_side)
  );

  spotrad_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (geo_v),
    .x_i     (d2),
    .side_i  (geo_side),
    .valid_o (sq_v),
    .root_o  (len),
    .side_o  (sq_side)
  );

  spotrad_dirdiv u_dirdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .len_i   (len),
    .side_i  (sq_side),
    .valid_o (dd_v),
    .side_o  (dd_side)
  );

  spotrad_falloff u_falloff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dd_v),
    .side_i  (dd_side),
    .cfg_i   (cfg_q),
    .valid_o (fo_v),
    .f_o     (f),
    .side_o  (fo_side)
  );

  spotrad_radiance u_radiance (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fo_v),
    .f_i     (f),
    .side_i  (fo_side),
    .cfg_i   (cfg_q),
    .valid_o (out_valid_o),
    .res_o   (out_data_o)
  );

endmodule
